### hw/rtl/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

  localparam int RawW   = 20;
  localparam int TrimW  = 48;
  localparam int CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_A = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_B = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_TRIM_C = 2'd3;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [RawW-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        zero_divisor;
  } out_item_t;

  typedef struct packed {
    logic [TrimW-1:0] temp_trim;
    logic [TrimW-1:0] press_trim_a;
    logic [TrimW-1:0] press_trim_b;
    logic [TrimW-1:0] press_trim_c;
  } trim_t;

  // Handshake between the sequencer and a multi-cycle arithmetic unit.
  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } unit_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/barometric_sample_compensator.sv
// Channel   Ports                           Moves
// input     in_valid/in_ready/in_data       one reading (mode, raw_sample)
// result    out_valid/out_ready/out_data    one compensated result
// config    cfg_we/cfg_index/cfg_wdata      one 48-bit trim word, no wait
//
// Products go through the shared 64-bit multiplier, three for a temperature and up to ten
// for a pressure, and the one-bit-a-cycle divider yields the pressure quotient. Reset is
// synchronous and clears the trims, the fine temperature and all control state. A
// two-entry queue keeps taking transfers while the sequencer is busy; a waiting result
// holds only the sequencer.
`default_nettype none
module barometric_sample_compensator (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  bsc_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output bsc_pkg::out_item_t   out_data,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [47:0]           cfg_wdata
);

  // The trim words must be written by the user only while the block is idle (the
  // block does not enforce it), so the sequencer reads them directly.
  bsc_pkg::trim_t     trim_r;
  logic               q_valid, q_pop;
  bsc_pkg::in_item_t  q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::REG_TEMP_TRIM:    trim_r.temp_trim    <= cfg_wdata;
        bsc_pkg::REG_PRESS_TRIM_A: trim_r.press_trim_a <= cfg_wdata;
        bsc_pkg::REG_PRESS_TRIM_B: trim_r.press_trim_b <= cfg_wdata;
        bsc_pkg::REG_PRESS_TRIM_C: trim_r.press_trim_c <= cfg_wdata;
        default: trim_r <= trim_r;
      endcase
    end
  end

  // Front: accepts transfers and queues them with their mode.
  bsc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // Back: steps through the compensation on the shared arithmetic units.
  bsc_core u_core (
    .clk(clk), .rst_n(rst_n), .trim(trim_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/bsc_front.sv
`default_nettype none
module bsc_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bsc_pkg::in_item_t   in_data,
  output logic                q_valid,
  output bsc_pkg::in_item_t   q_item,
  input  wire                 q_pop
);

  // Two-entry queue decoupling the input from the sequencer.
  bsc_pkg::in_item_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bsc_mul.sv
`default_nettype none
module bsc_mul (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bsc_pkg::unit_req_t  req,
  output bsc_pkg::unit_rsp_t  rsp
);

  // Low 64 bits of a 64 x 64 product from three 32 x 32 partial products,
  // one per cycle through a single multiplier.
  logic [63:0] a_r, b_r, prod_r, acc_r;
  logic [2:0]  cnt_r;
  logic        busy_r, done_r;
  logic [31:0] mx, my;

  always_comb begin
    case (cnt_r)
      3'd0:    begin mx = a_r[31:0];  my = b_r[31:0];  end
      3'd1:    begin mx = a_r[31:0];  my = b_r[63:32]; end
      default: begin mx = a_r[63:32]; my = b_r[31:0];  end
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.op_a;
      b_r <= req.op_b;
    end
    prod_r <= {32'd0, mx} * {32'd0, my};
    case (cnt_r)
      3'd1:    acc_r <= prod_r;
      3'd2:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
      3'd3:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
      default: acc_r <= acc_r;
    endcase
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd3) busy_r <= 1'b0;
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bsc_div.sv
`default_nettype none
module bsc_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bsc_pkg::unit_req_t  req,
  output bsc_pkg::unit_rsp_t  rsp
);

  // Signed division truncating toward zero; restoring, one bit a cycle.
  logic [63:0] den_r, quo_r, rem_r;
  logic        neg_r, busy_r, done_r;
  logic [6:0]  cnt_r;
  logic [64:0] shifted, diff;

  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, den_r};
  assign rsp.done   = done_r;
  assign rsp.result = neg_r ? (64'd0 - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.op_a[63] ? (64'd0 - req.op_a) : req.op_a;
      den_r <= req.op_b[63] ? (64'd0 - req.op_b) : req.op_b;
      neg_r <= req.op_a[63] ^ req.op_b[63];
      rem_r <= 64'd0;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_r <= diff[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd63);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        if (cnt_r == 7'd63) busy_r <= 1'b0;
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bsc_core.sv
`default_nettype none
module bsc_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bsc_pkg::trim_t      trim,
  input  wire                 q_valid,
  input  bsc_pkg::in_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output bsc_pkg::out_item_t  out_data
);

  typedef enum logic [4:0] {
    S_IDLE, T_A, T_B, T_C,
    P_A, P_B, P_C, P_D, P_E, P_F, P_G, P_DIV, P_H, P_I, P_J, S_OUT
  } state_t;

  state_t state_r;
  logic   issued_r;
  logic [19:0] raw_r;
  logic [31:0] ft_r;
  logic [63:0] v1_r, v2_r, tmp_r, q_r;
  bsc_pkg::out_item_t res_r, out_r;
  logic   out_valid_r;

  bsc_pkg::unit_req_t mul_req, div_req;
  bsc_pkg::unit_rsp_t mul_rsp, div_rsp;

  bsc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  bsc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Trim fields.
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, trim.temp_trim[15:0]};
  assign t2 = {{16{trim.temp_trim[31]}}, trim.temp_trim[31:16]};
  assign t3 = {{16{trim.temp_trim[47]}}, trim.temp_trim[47:32]};
  assign p1 = {48'd0, trim.press_trim_a[15:0]};
  assign p2 = {{48{trim.press_trim_a[31]}}, trim.press_trim_a[31:16]};
  assign p3 = {{48{trim.press_trim_a[47]}}, trim.press_trim_a[47:32]};
  assign p4 = {{48{trim.press_trim_b[15]}}, trim.press_trim_b[15:0]};
  assign p5 = {{48{trim.press_trim_b[31]}}, trim.press_trim_b[31:16]};
  assign p6 = {{48{trim.press_trim_b[47]}}, trim.press_trim_b[47:32]};
  assign p7 = {{48{trim.press_trim_c[15]}}, trim.press_trim_c[15:0]};
  assign p8 = {{48{trim.press_trim_c[31]}}, trim.press_trim_c[31:16]};
  assign p9 = {{48{trim.press_trim_c[47]}}, trim.press_trim_c[47:32]};

  logic [31:0] d3, d4, res32, ft_w, ft5;
  logic [63:0] v1w, pw, q13, sum_w, pres_w;
  logic        is_mul;
  logic [63:0] mul_a, mul_b;

  assign d3    = {15'd0, raw_r[19:3]} - {t1[30:0], 1'b0};
  assign d4    = {16'd0, raw_r[19:4]} - t1;
  assign res32 = mul_rsp.result[31:0];
  assign ft_w  = tmp_r[31:0] + 32'($signed(res32) >>> 14);
  assign ft5   = (ft_w << 2) + ft_w + 32'd128;
  assign v1w   = {{32{ft_r[31]}}, ft_r} - 64'd128000;
  assign pw    = 64'd1048576 - {44'd0, raw_r};
  assign q13   = 64'($signed(q_r) >>> 13);
  assign sum_w = q_r + v1_r + 64'($signed(mul_rsp.result) >>> 19);
  assign pres_w = 64'($signed(sum_w) >>> 8) + (p7 << 4);

  always_comb begin
    is_mul = 1'b1;
    mul_a  = 64'd0;
    mul_b  = 64'd0;
    case (state_r)
      T_A: begin mul_a = {32'd0, d3};         mul_b = {32'd0, t2}; end
      T_B: begin mul_a = {32'd0, d4};         mul_b = {32'd0, d4}; end
      T_C: begin mul_a = {32'd0, v2_r[31:0]}; mul_b = {32'd0, t3}; end
      P_A: begin mul_a = v1w;  mul_b = v1w; end
      P_B: begin mul_a = tmp_r; mul_b = p6; end
      P_C: begin mul_a = v1w;  mul_b = p5; end
      P_D: begin mul_a = tmp_r; mul_b = p3; end
      P_E: begin mul_a = v1w;  mul_b = p2; end
      P_F: begin mul_a = (64'd1 << 47) + tmp_r; mul_b = p1; end
      P_G: begin mul_a = (pw << 31) - v2_r; mul_b = 64'd3125; end
      P_H: begin mul_a = p9;   mul_b = q13; end
      P_I: begin mul_a = tmp_r; mul_b = q13; end
      P_J: begin mul_a = p8;   mul_b = q_r; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_req.start = is_mul && !issued_r;
  assign mul_req.op_a  = mul_a;
  assign mul_req.op_b  = mul_b;
  assign div_req.start = (state_r == P_G) && mul_rsp.done;
  assign div_req.op_a  = mul_rsp.result;
  assign div_req.op_b  = v1_r;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ft_r        <= 32'd0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      if (mul_req.start) issued_r <= 1'b1;
      if (mul_rsp.done)  issued_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            raw_r   <= q_item.raw_sample;
            state_r <= (q_item.mode == bsc_pkg::MODE_PRESS) ? P_A : T_A;
          end
        end
        T_A: if (mul_rsp.done) begin
          tmp_r   <= {32'd0, 32'($signed(res32) >>> 11)};
          state_r <= T_B;
        end
        T_B: if (mul_rsp.done) begin
          v2_r    <= {32'd0, 32'($signed(res32) >>> 12)};
          state_r <= T_C;
        end
        T_C: if (mul_rsp.done) begin
          ft_r  <= ft_w;
          res_r <= '{kind: bsc_pkg::MODE_TEMP,
                     temperature_centi: 32'($signed(ft5) >>> 8),
                     pressure_q24_8: 32'd0, zero_divisor: 1'b0};
          state_r <= S_OUT;
        end
        P_A: if (mul_rsp.done) begin
          tmp_r <= mul_rsp.result;
          state_r <= P_B;
        end
        P_B: if (mul_rsp.done) begin
          v2_r <= mul_rsp.result;
          state_r <= P_C;
        end
        P_C: if (mul_rsp.done) begin
          v2_r <= v2_r + (mul_rsp.result << 17) + (p4 << 35);
          state_r <= P_D;
        end
        P_D: if (mul_rsp.done) begin
          tmp_r <= 64'($signed(mul_rsp.result) >>> 8);
          state_r <= P_E;
        end
        P_E: if (mul_rsp.done) begin
          tmp_r <= tmp_r + (mul_rsp.result << 12);
          state_r <= P_F;
        end
        P_F: if (mul_rsp.done) begin
          v1_r <= 64'($signed(mul_rsp.result) >>> 33);
          if (64'($signed(mul_rsp.result) >>> 33) == 64'd0) begin
            res_r <= '{kind: bsc_pkg::MODE_PRESS, temperature_centi: 32'd0,
                       pressure_q24_8: 32'd0, zero_divisor: 1'b1};
            state_r <= S_OUT;
          end else begin
            state_r <= P_G;
          end
        end
        P_G: if (mul_rsp.done) state_r <= P_DIV;
        P_DIV: if (div_rsp.done) begin
          q_r <= div_rsp.result;
          state_r <= P_H;
        end
        P_H: if (mul_rsp.done) begin
          tmp_r <= mul_rsp.result;
          state_r <= P_I;
        end
        P_I: if (mul_rsp.done) begin
          v1_r <= 64'($signed(mul_rsp.result) >>> 25);
          state_r <= P_J;
        end
        P_J: if (mul_rsp.done) begin
          res_r <= '{kind: bsc_pkg::MODE_PRESS, temperature_centi: 32'd0,
                     pressure_q24_8: pres_w[31:0], zero_divisor: 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_ready) begin
          out_r       <= res_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bsc_checker.sv
`default_nettype none
module bsc_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  bsc_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_temp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> out_data.pressure_q24_8 == 32'd0 &&
                                    !out_data.zero_divisor)
    else $error("temperature result carries pressure fields");

  a_press_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.temperature_centi == 32'd0)
    else $error("pressure result carries a temperature");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_divisor |-> out_data.pressure_q24_8 == 32'd0)
    else $error("zero divisor with nonzero pressure");

endmodule

bind barometric_sample_compensator bsc_checker u_bsc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bsc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  barometric_sample_compensator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps its own copy of the trims and the fine temperature.
  logic [47:0] trim_t_w, trim_pa_w, trim_pb_w, trim_pc_w;
  logic signed [31:0] fine_temp;
  bsc_pkg::out_item_t expected_results[$];
  int errors = 0;
  int row_errors = 0;
  int results_seen = 0;
  int temp_seen = 0;
  int press_seen = 0;
  int zero_div_seen = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit hold_receiver = 1'b0;
  longint cycle_count = 0;

  function automatic logic signed [63:0] sext16(input logic [47:0] w, input int pos);
    logic [15:0] s;
    s = w[pos +: 16];
    return {{48{s[15]}}, s};
  endfunction

  // Signed division truncating toward zero; the quotient wraps on overflow.
  function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic bsc_pkg::out_item_t compensate(input bsc_pkg::in_item_t item);
    bsc_pkg::out_item_t r;
    logic signed [31:0] t1, t2, t3, d3, d4, tv1, tv2, raw32;
    logic signed [63:0] ft, v1, v2, p, p1;
    r = '0;
    if (item.mode == bsc_pkg::MODE_TEMP) begin
      raw32 = {12'd0, item.raw_sample};
      t1 = {16'd0, trim_t_w[15:0]};
      t2 = 32'(sext16(trim_t_w, 16));
      t3 = 32'(sext16(trim_t_w, 32));
      d3 = (raw32 >>> 3) - (t1 <<< 1);
      d4 = (raw32 >>> 4) - t1;
      tv1 = (d3 * t2) >>> 11;
      tv2 = (((d4 * d4) >>> 12) * t3) >>> 14;
      fine_temp = tv1 + tv2;
      r.kind = bsc_pkg::MODE_TEMP;
      r.temperature_centi = (fine_temp * 5 + 128) >>> 8;
    end else begin
      r.kind = bsc_pkg::MODE_PRESS;
      p1 = {48'd0, trim_pa_w[15:0]};
      ft = fine_temp;
      v1 = ft - 64'sd128000;
      v2 = v1 * v1 * sext16(trim_pb_w, 32);
      v2 = v2 + ((v1 * sext16(trim_pb_w, 16)) <<< 17);
      v2 = v2 + (sext16(trim_pb_w, 0) <<< 35);
      v1 = ((v1 * v1 * sext16(trim_pa_w, 32)) >>> 8) +
           ((v1 * sext16(trim_pa_w, 16)) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.zero_divisor = 1'b1;
      end else begin
        p = 64'sd1048576 - {44'd0, item.raw_sample};
        p = div_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
        v1 = (sext16(trim_pc_w, 32) * (p >>> 13) * (p >>> 13)) >>> 25;
        v2 = (sext16(trim_pc_w, 16) * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (sext16(trim_pc_w, 0) <<< 4);
        r.pressure_q24_8 = p[31:0];
      end
    end
    return r;
  endfunction

  // Offers one reading, holds it until the transfer, and records its prediction.
  // Valid stays high into the next reading; the caller drops it after a batch.
  task automatic send_reading(input bsc_pkg::in_item_t item, input bit has_typed,
                              input bsc_pkg::out_item_t typed);
    bsc_pkg::out_item_t pred;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = compensate(item);
    if (has_typed && pred !== typed) begin
      $error("typed row disagrees with predictor: %h vs %h", typed, pred);
      row_errors++;
    end
    expected_results.push_back(has_typed ? typed : pred);
    @(negedge clk);
  endtask

  task automatic write_trim(input logic [1:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bsc_pkg::REG_TEMP_TRIM: trim_t_w = val;
      bsc_pkg::REG_PRESS_TRIM_A: trim_pa_w = val;
      bsc_pkg::REG_PRESS_TRIM_B: trim_pb_w = val;
      default: trim_pc_w = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every prediction has been matched, then lets the pipeline drain.
  task automatic drain;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Typical factory trims, two extreme sets, and random trims with temperature words
  // close enough to real ones that the fine temperature lands in a useful range.
  task automatic load_trims(input int style);
    logic [47:0] w;
    case (style)
      0: begin
        write_trim(bsc_pkg::REG_TEMP_TRIM, {16'hFC18, 16'h6823, 16'd27504});
        write_trim(bsc_pkg::REG_PRESS_TRIM_A, {16'hD0D0, 16'hD65D, 16'd36477});
        write_trim(bsc_pkg::REG_PRESS_TRIM_B, {16'hFFF9, 16'h008C, 16'd2855});
        write_trim(bsc_pkg::REG_PRESS_TRIM_C, {16'd6000, 16'hC4F0, 16'd15500});
      end
      1: begin
        write_trim(bsc_pkg::REG_TEMP_TRIM, 48'hFFFF_FFFF_FFFF);
        write_trim(bsc_pkg::REG_PRESS_TRIM_A, 48'hFFFF_FFFF_FFFF);
        write_trim(bsc_pkg::REG_PRESS_TRIM_B, 48'hFFFF_FFFF_FFFF);
        write_trim(bsc_pkg::REG_PRESS_TRIM_C, 48'hFFFF_FFFF_FFFF);
      end
      2: begin
        write_trim(bsc_pkg::REG_TEMP_TRIM, 48'h8000_8000_0000);
        write_trim(bsc_pkg::REG_PRESS_TRIM_A, 48'h8000_8000_0001);
        write_trim(bsc_pkg::REG_PRESS_TRIM_B, 48'h8000_7FFF_8000);
        write_trim(bsc_pkg::REG_PRESS_TRIM_C, 48'h7FFF_8000_7FFF);
      end
      default: begin
        w = {16'($urandom_range(16'hFFFF)), 16'(26000 + $urandom_range(2000)),
             16'(27000 + $urandom_range(2000))};
        write_trim(bsc_pkg::REG_TEMP_TRIM, w);
        w = {16'($urandom), 16'($urandom),
             16'(($urandom_range(3) == 0) ? 0 : $urandom_range(16'hFFFF))};
        write_trim(bsc_pkg::REG_PRESS_TRIM_A, w);
        write_trim(bsc_pkg::REG_PRESS_TRIM_B, {$urandom, 16'($urandom)});
        write_trim(bsc_pkg::REG_PRESS_TRIM_C, {$urandom, 16'($urandom)});
      end
    endcase
  endtask

  // Directed rows: the typed expectations hold after reset (all trims zero, so the
  // fine temperature stays zero and the pressure divisor is zero) and for the
  // extremes; the rest are left to the predictor.
  typedef struct {
    bsc_pkg::in_item_t item;
    bit has_typed;
    bsc_pkg::out_item_t typed;
  } row_t;

  row_t directed_rows[$];

  task automatic add_row(input logic mode, input logic [19:0] raw, input bit has_typed,
                         input bsc_pkg::out_item_t typed);
    row_t r;
    r.item.mode = mode;
    r.item.raw_sample = raw;
    r.has_typed = has_typed;
    r.typed = typed;
    directed_rows.push_back(r);
  endtask

  task automatic run_random(input int count);
    bsc_pkg::in_item_t item;
    for (int i = 0; i < count; i++) begin
      item.mode = ($urandom_range(99) < 55) ? bsc_pkg::MODE_PRESS : bsc_pkg::MODE_TEMP;
      case ($urandom_range(5))
        0: item.raw_sample = 20'h00000;
        1: item.raw_sample = 20'hFFFFF;
        default: item.raw_sample = (item.mode == bsc_pkg::MODE_TEMP) ?
          20'(400000 + $urandom_range(250000)) : 20'($urandom);
      endcase
      send_reading(item, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  // Result side: random stalls per the current percentage, plus a long hold-off
  // on request from the stimulus process.
  always @(negedge clk) begin
    if (!rst_n || hold_receiver) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    bsc_pkg::out_item_t exp_r;
    int n_bad;
    n_bad = 0;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        n_bad++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.kind == bsc_pkg::MODE_TEMP) temp_seen <= temp_seen + 1;
        else press_seen <= press_seen + 1;
        if (exp_r.zero_divisor) zero_div_seen <= zero_div_seen + 1;
        if (out_data.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, out_data.kind);
          n_bad++;
        end
        if (out_data.temperature_centi !== exp_r.temperature_centi) begin
          $error("temperature_centi: expected %0d, got %0d",
                 $signed(exp_r.temperature_centi), $signed(out_data.temperature_centi));
          n_bad++;
        end
        if (out_data.pressure_q24_8 !== exp_r.pressure_q24_8) begin
          $error("pressure_q24_8: expected %0d, got %0d",
                 exp_r.pressure_q24_8, out_data.pressure_q24_8);
          n_bad++;
        end
        if (out_data.zero_divisor !== exp_r.zero_divisor) begin
          $error("zero_divisor: expected %0d, got %0d",
                 exp_r.zero_divisor, out_data.zero_divisor);
          n_bad++;
        end
      end
      errors <= errors + n_bad;
    end
  end

  // Watchdog: the 567 readings of the regression, even with heavy stalls, stay
  // far below this.
  always @(posedge clk) begin
    if (cycle_count > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    bsc_pkg::out_item_t z;
    bsc_pkg::out_item_t t_lo;
    trim_t_w = '0;
    trim_pa_w = '0;
    trim_pb_w = '0;
    trim_pc_w = '0;
    fine_temp = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // After reset every trim is zero: temperature is zero, pressure hits the
    // zero divisor. Pressure before any temperature reading is covered here too.
    z = '0;
    z.kind = bsc_pkg::MODE_PRESS;
    z.zero_divisor = 1'b1;
    t_lo = '0;
    t_lo.kind = bsc_pkg::MODE_TEMP;
    add_row(bsc_pkg::MODE_PRESS, 20'h80000, 1'b1, z);
    add_row(bsc_pkg::MODE_TEMP, 20'h00000, 1'b1, t_lo);
    add_row(bsc_pkg::MODE_TEMP, 20'hFFFFF, 1'b1, t_lo);
    add_row(bsc_pkg::MODE_PRESS, 20'hFFFFF, 1'b1, z);
    add_row(bsc_pkg::MODE_PRESS, 20'h00000, 1'b1, z);
    foreach (directed_rows[i])
      send_reading(directed_rows[i].item, directed_rows[i].has_typed, directed_rows[i].typed);
    in_valid <= 1'b0;
    drain();

    // Typical trims, extreme raw readings and every mode.
    load_trims(0);
    directed_rows.delete();
    add_row(bsc_pkg::MODE_TEMP, 20'd519888, 1'b0, '0);
    add_row(bsc_pkg::MODE_PRESS, 20'd415148, 1'b0, '0);
    add_row(bsc_pkg::MODE_PRESS, 20'h00000, 1'b0, '0);
    add_row(bsc_pkg::MODE_PRESS, 20'hFFFFF, 1'b0, '0);
    add_row(bsc_pkg::MODE_TEMP, 20'h00000, 1'b0, '0);
    add_row(bsc_pkg::MODE_PRESS, 20'h55555, 1'b0, '0);
    add_row(bsc_pkg::MODE_TEMP, 20'hFFFFF, 1'b0, '0);
    add_row(bsc_pkg::MODE_PRESS, 20'hAAAAA, 1'b0, '0);
    foreach (directed_rows[i])
      send_reading(directed_rows[i].item, 1'b0, '0);
    in_valid <= 1'b0;
    drain();

    // Extreme trim words: all ones, then the most negative and positive slices.
    for (int s = 1; s <= 2; s++) begin
      load_trims(s);
      directed_rows.delete();
      add_row(bsc_pkg::MODE_TEMP, 20'hFFFFF, 1'b0, '0);
      add_row(bsc_pkg::MODE_PRESS, 20'h00000, 1'b0, '0);
      add_row(bsc_pkg::MODE_TEMP, 20'h00000, 1'b0, '0);
      add_row(bsc_pkg::MODE_PRESS, 20'hFFFFF, 1'b0, '0);
      foreach (directed_rows[i])
        send_reading(directed_rows[i].item, 1'b0, '0);
      in_valid <= 1'b0;
      drain();
    end

    // Random phases under the three idle patterns with trims reloaded each time.
    sender_idle_pct = 20;
    receiver_idle_pct = 70;
    load_trims(3);
    run_random(90);
    drain();
    load_trims(0);
    run_random(90);
    drain();

    // Long receiver hold-off while readings keep coming, so the queue fills.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_receiver = 1'b1;
    fork
      begin
        run_random(6);
      end
      begin
        repeat (600) @(negedge clk);
        hold_receiver = 1'b0;
      end
    join
    drain();

    sender_idle_pct = 70;
    receiver_idle_pct = 20;
    load_trims(3);
    run_random(90);
    drain();
    load_trims(0);
    run_random(90);
    drain();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    load_trims(3);
    run_random(90);
    drain();
    load_trims(3);
    run_random(90);
    drain();

    $display("Covered %0d results: %0d temperature, %0d pressure, %0d with zero divisor,",
             results_seen, temp_seen, press_seen, zero_div_seen);
    $display("under extreme and random trims, three idle patterns and a full-queue stall.");
    if (errors == 0 && row_errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_front.sv
hw/rtl/bsc_mul.sv
hw/rtl/bsc_div.sv
hw/rtl/bsc_core.sv
hw/rtl/barometric_sample_compensator.sv
hw/rtl/bsc_checker.sv
test/tb.sv
